[hw/rtl/assert_macros.svh]
// assertion helpers shared by the rtl files
// ALD_ASSERT checks outside reset, ALD_ASSERT_RST also checks while reset is applied
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ALD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ALD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ALD_ASSERT(label, prop, msg)
`define ALD_ASSERT_RST(label, prop, msg)
`endif

`endif

[hw/rtl/ald_pkg.sv]
// ----------------------------------------------------------------------------
// ald_pkg
// Shared widths, codes, register defaults and stage types of the averaged
// level detector.
// ----------------------------------------------------------------------------
package ald_pkg;

  // field widths
  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEVEL_W   = 3;
  localparam int unsigned EVENT_W   = 6;
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned DEFAULT_WINDOW_DEPTH = 16;

  // request codes
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_ACK    = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_ONE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_TWO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_THREE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_FOUR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EVENT_ENABLE = 3'd4;

  // register reset values
  localparam logic [BYTE_W-1:0]  THRESH_ONE_RST   = 8'd200;
  localparam logic [BYTE_W-1:0]  THRESH_TWO_RST   = 8'd150;
  localparam logic [BYTE_W-1:0]  THRESH_THREE_RST = 8'd100;
  localparam logic [BYTE_W-1:0]  THRESH_FOUR_RST  = 8'd50;
  localparam logic [EVENT_W-1:0] EVENT_ENABLE_RST = 6'd0;

  // press levels
  localparam logic [LEVEL_W-1:0] LVL_RELEASED = 3'd0;
  localparam logic [LEVEL_W-1:0] LVL_ONE      = 3'd1;
  localparam logic [LEVEL_W-1:0] LVL_TWO      = 3'd2;
  localparam logic [LEVEL_W-1:0] LVL_THREE    = 3'd3;
  localparam logic [LEVEL_W-1:0] LVL_FOUR     = 3'd4;

  // event bit positions, bits 0 to 3 are press to level one to four
  localparam int unsigned EV_RELEASE = 4;
  localparam int unsigned EV_CHANGE  = 5;

  // per-item control that travels with the window stages
  typedef struct packed {
    logic               ack;
    logic               prime;
    logic [EVENT_W-1:0] ack_mask;
  } win_ctrl_t;

endpackage

[hw/rtl/ald_window.sv]
// ----------------------------------------------------------------------------
// ald_window
// Sample window memory and running sum. Reads the slot to be replaced at the
// input transfer, then subtracts the old entry, adds the new sample and
// writes it back as the item leaves the first stage register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ald_window #(
  parameter int unsigned WINDOW_DEPTH = ald_pkg::DEFAULT_WINDOW_DEPTH
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             in_valid,
  output logic                                             in_stall,
  input  logic                                             in_req_type,
  input  logic [ald_pkg::SAMPLE_W-1:0]                     in_sample,
  input  logic [ald_pkg::EVENT_W-1:0]                      in_ack_mask,
  output logic                                             p2_valid,
  input  logic                                             p2_ready,
  output ald_pkg::win_ctrl_t                               p2_ctrl,
  output logic [ald_pkg::SAMPLE_W+$clog2(WINDOW_DEPTH)-1:0] p2_sum
);
  import ald_pkg::*;

  localparam int unsigned SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int unsigned SUM_W  = SAMPLE_W + SLOT_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);

  logic [SAMPLE_W-1:0]     window_mem [WINDOW_DEPTH];
  logic [SAMPLE_W-1:0]     rd_data_r;

  logic [SLOT_W-1:0]       write_slot_r, write_slot_nxt;
  logic                    primed_r, primed_nxt;

  logic                    p1_valid_r;
  win_ctrl_t               p1_ctrl_r;
  logic [SAMPLE_W-1:0]     p1_sample_r;
  logic [SLOT_W-1:0]       p1_slot_r;

  logic [WINDOW_DEPTH-1:0] written_r, written_nxt;
  logic [SAMPLE_W-1:0]     fill_r;
  logic [SUM_W-1:0]        sum_r, sum_nxt;

  logic                    p2_valid_r;
  win_ctrl_t               p2_ctrl_r;

  logic                    is_ack, in_take, p2_free, p1_free, p1_move, p1_write;
  logic [SAMPLE_W-1:0]     old_entry;
  win_ctrl_t               in_ctrl;

  // stage flow
  assign p2_free  = !p2_valid_r || p2_ready;
  assign p1_move  = p1_valid_r && p2_free;
  assign p1_free  = !p1_valid_r || p2_free;
  assign in_stall = !p1_free;
  assign in_take  = in_valid && p1_free;
  assign p1_write = p1_move && !p1_ctrl_r.ack && !p1_ctrl_r.prime;

  // decode of the incoming transfer
  always_comb begin
    is_ack           = (in_req_type == REQ_ACK);
    in_ctrl.ack      = is_ack;
    in_ctrl.prime    = !is_ack && !primed_r;
    in_ctrl.ack_mask = in_ack_mask;
  end

  // slot pointer, the priming sample leaves it at zero
  always_comb begin
    write_slot_nxt = write_slot_r;
    primed_nxt     = primed_r;
    if (in_take && !is_ack) begin
      primed_nxt = 1'b1;
      if (primed_r) begin
        write_slot_nxt = (write_slot_r == LAST_SLOT) ? '0 : write_slot_r + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_slot_r <= '0;
      primed_r     <= 1'b0;
    end else begin
      write_slot_r <= write_slot_nxt;
      primed_r     <= primed_nxt;
    end
  end

  // window memory, one read at the transfer and one write-back
  always_ff @(posedge clk) begin
    if (in_take) begin
      rd_data_r <= window_mem[write_slot_r];
    end
    if (p1_write) begin
      window_mem[p1_slot_r] <= p1_sample_r;
    end
  end

  // first stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (in_take) begin
      p1_valid_r <= 1'b1;
    end else if (p1_move) begin
      p1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      p1_ctrl_r   <= in_ctrl;
      p1_sample_r <= in_sample;
      p1_slot_r   <= write_slot_r;
    end
  end

  // unwritten entries read as the priming value
  assign old_entry = written_r[p1_slot_r] ? rd_data_r : fill_r;

  // running sum update
  always_comb begin
    sum_nxt     = sum_r;
    written_nxt = written_r;
    if (p1_move && !p1_ctrl_r.ack) begin
      if (p1_ctrl_r.prime) begin
        sum_nxt     = SUM_W'(SUM_W'(p1_sample_r) * SUM_W'(WINDOW_DEPTH));
        written_nxt = '0;
      end else begin
        sum_nxt                = sum_r - SUM_W'(old_entry) + SUM_W'(p1_sample_r);
        written_nxt[p1_slot_r] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= '0;
      written_r <= '0;
      fill_r    <= '0;
    end else begin
      sum_r     <= sum_nxt;
      written_r <= written_nxt;
      if (p1_move && p1_ctrl_r.prime) begin
        fill_r <= p1_sample_r;
      end
    end
  end

  // second stage register, the sum register holds its value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_valid_r <= 1'b0;
    end else if (p1_move) begin
      p2_valid_r <= 1'b1;
    end else if (p2_ready) begin
      p2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_move) begin
      p2_ctrl_r <= p1_ctrl_r;
    end
  end

  assign p2_valid = p2_valid_r;
  assign p2_ctrl  = p2_ctrl_r;
  assign p2_sum   = sum_r;

  // checks
  `ALD_ASSERT(a_no_slot_clash, (in_take && p1_write) |-> (write_slot_r != p1_slot_r), "read and write-back hit the same slot")
  `ALD_ASSERT(a_prime_clears_mask, (p1_move && p1_ctrl_r.prime) |=> (written_r == '0), "priming left written entries")
  `ALD_ASSERT(a_sample_primes, (in_take && !is_ack) |=> primed_r, "sample transfer did not prime the window")
  `ALD_ASSERT_RST(a_reset_slot, !rst_n |=> ((write_slot_r == '0) && !primed_r && !p1_valid_r), "reset left window control set")

endmodule

[hw/rtl/averaged_level_detector.sv]
// ----------------------------------------------------------------------------
// averaged_level_detector
// Path: window first stage, window second stage, quotient stage, output register.
// Throughput: one item per cycle while the output is not stalled, set by the
// window memory read at the transfer and written back on a different slot.
// Reset: synchronous, clears the pipeline, the window bookkeeping and the
// event flags, and loads the threshold defaults; no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module averaged_level_detector #(
  parameter int unsigned WINDOW_DEPTH = ald_pkg::DEFAULT_WINDOW_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ald_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ald_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [ald_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic [ald_pkg::EVENT_W-1:0]   in_ack_mask,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ald_pkg::SAMPLE_W-1:0]  out_average_wide,
  output logic [ald_pkg::BYTE_W-1:0]    out_average_byte,
  output logic [ald_pkg::LEVEL_W-1:0]   out_press_level,
  output logic [ald_pkg::EVENT_W-1:0]   out_new_events,
  output logic [ald_pkg::EVENT_W-1:0]   out_pending_events,
  output logic                          out_irq
);
  import ald_pkg::*;

  localparam int unsigned SUM_W = SAMPLE_W + $clog2(WINDOW_DEPTH);
  localparam logic [SUM_W-1:0] HALF_DEPTH = SUM_W'(WINDOW_DEPTH / 2);
  localparam logic [SUM_W-1:0] DEPTH_VAL  = SUM_W'(WINDOW_DEPTH);
  localparam logic [SUM_W-1:0] RECIP      = SUM_W'((2 ** SUM_W) / WINDOW_DEPTH);

  // configuration registers
  logic [BYTE_W-1:0]    thresh_one_r, thresh_two_r, thresh_three_r, thresh_four_r;
  logic [EVENT_W-1:0]   event_enable_r;

  // window stage outputs
  logic                 p2_valid, p2_ready;
  win_ctrl_t            p2_ctrl;
  logic [SUM_W-1:0]     p2_sum;

  // quotient stage
  logic                 p3_valid_r;
  win_ctrl_t            p3_ctrl_r;
  logic [SAMPLE_W-1:0]  p3_quo_r;
  logic [SUM_W-1:0]     p3_x_r;
  logic [SUM_W-1:0]     rounded_sum;
  logic [2*SUM_W-1:0]   recip_prod;

  // result stage
  logic                 out_valid_r;
  logic                 out_free, p3_open, p3_move;
  logic [SUM_W-1:0]     quo_back, quo_rem;
  logic [SAMPLE_W-1:0]  wide;
  logic [SAMPLE_W:0]    byte_sum;
  logic [BYTE_W-1:0]    byte_val;
  logic [LEVEL_W-1:0]   sample_level, level;
  logic [EVENT_W-1:0]   ev, raised;
  logic [LEVEL_W-1:0]   last_level_r, last_level_nxt;
  logic [EVENT_W-1:0]   pending_r, pending_nxt;

  logic [SAMPLE_W-1:0]  out_wide_r;
  logic [BYTE_W-1:0]    out_byte_r;
  logic [LEVEL_W-1:0]   out_level_r;
  logic [EVENT_W-1:0]   out_new_r, out_pending_r;
  logic                 out_irq_r;

  // configuration writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_one_r   <= THRESH_ONE_RST;
      thresh_two_r   <= THRESH_TWO_RST;
      thresh_three_r <= THRESH_THREE_RST;
      thresh_four_r  <= THRESH_FOUR_RST;
      event_enable_r <= EVENT_ENABLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESH_ONE:   thresh_one_r   <= cfg_data;
        CFG_THRESH_TWO:   thresh_two_r   <= cfg_data;
        CFG_THRESH_THREE: thresh_three_r <= cfg_data;
        CFG_THRESH_FOUR:  thresh_four_r  <= cfg_data;
        CFG_EVENT_ENABLE: event_enable_r <= cfg_data[EVENT_W-1:0];
        default: ;
      endcase
    end
  end

  // window memory and running sum
  ald_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_sample   (in_sample),
    .in_ack_mask (in_ack_mask),
    .p2_valid    (p2_valid),
    .p2_ready    (p2_ready),
    .p2_ctrl     (p2_ctrl),
    .p2_sum      (p2_sum)
  );

  // stage flow toward the output register
  assign out_free = !out_valid_r || !out_stall;
  assign p3_move  = p3_valid_r && out_free;
  assign p3_open  = !p3_valid_r || out_free;
  assign p2_ready = p3_open;

  // quotient estimate by reciprocal, low by at most one
  assign rounded_sum = p2_sum + HALF_DEPTH;
  assign recip_prod  = (2*SUM_W)'(rounded_sum) * (2*SUM_W)'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_valid_r <= 1'b0;
    end else if (p2_valid && p3_open) begin
      p3_valid_r <= 1'b1;
    end else if (out_free) begin
      p3_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_valid && p3_open) begin
      p3_ctrl_r <= p2_ctrl;
      p3_x_r    <= rounded_sum;
      p3_quo_r  <= recip_prod[SUM_W +: SAMPLE_W];
    end
  end

  // quotient correction and byte rounding with saturation
  always_comb begin
    quo_back = SUM_W'(SUM_W'(p3_quo_r) * DEPTH_VAL);
    quo_rem  = p3_x_r - quo_back;
    wide     = (quo_rem >= DEPTH_VAL) ? p3_quo_r + SAMPLE_W'(1) : p3_quo_r;
    byte_sum = {1'b0, wide} + (SAMPLE_W + 1)'(2);
    byte_val = byte_sum[SAMPLE_W] ? {BYTE_W{1'b1}} : byte_sum[SAMPLE_W-1:2];
  end

  // thresholds checked in order, first one exceeded wins
  always_comb begin
    priority if (byte_val > thresh_one_r) begin
      sample_level = LVL_RELEASED;
    end else if (byte_val > thresh_two_r) begin
      sample_level = LVL_ONE;
    end else if (byte_val > thresh_three_r) begin
      sample_level = LVL_TWO;
    end else if (byte_val > thresh_four_r) begin
      sample_level = LVL_THREE;
    end else begin
      sample_level = LVL_FOUR;
    end
  end

  // level transition events against the previous level
  always_comb begin
    ev = '0;
    if (sample_level != LVL_RELEASED && sample_level > last_level_r) begin
      ev[sample_level - LEVEL_W'(1)] = 1'b1;
    end
    if (last_level_r != LVL_RELEASED && sample_level == LVL_RELEASED) begin
      ev[EV_RELEASE] = 1'b1;
    end
    if (sample_level != last_level_r) begin
      ev[EV_CHANGE] = 1'b1;
    end
  end

  // per-item state update: acknowledge, priming sample or normal sample
  always_comb begin
    level          = sample_level;
    raised         = '0;
    last_level_nxt = last_level_r;
    pending_nxt    = pending_r;
    if (p3_ctrl_r.ack) begin
      level       = last_level_r;
      pending_nxt = pending_r & ~p3_ctrl_r.ack_mask;
    end else begin
      last_level_nxt = sample_level;
      if (!p3_ctrl_r.prime && event_enable_r != '0) begin
        raised      = ev & event_enable_r;
        pending_nxt = pending_r | raised;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r <= LVL_RELEASED;
      pending_r    <= '0;
    end else if (p3_move) begin
      last_level_r <= last_level_nxt;
      pending_r    <= pending_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (p3_move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p3_move) begin
      out_wide_r    <= wide;
      out_byte_r    <= byte_val;
      out_level_r   <= level;
      out_new_r     <= raised;
      out_pending_r <= pending_nxt;
      out_irq_r     <= (event_enable_r != '0) && (pending_nxt != '0);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_average_wide   = out_wide_r;
  assign out_average_byte   = out_byte_r;
  assign out_press_level    = out_level_r;
  assign out_new_events     = out_new_r;
  assign out_pending_events = out_pending_r;
  assign out_irq            = out_irq_r;

  // checks
  `ALD_ASSERT(a_new_in_pending, out_valid_r |-> ((out_new_r & ~out_pending_r) == '0), "raised event missing from pending flags")
  `ALD_ASSERT(a_irq_source, (out_valid_r && out_irq_r) |-> ((event_enable_r != '0) && (out_pending_r != '0)), "irq without enabled pending flag")
  `ALD_ASSERT(a_level_range, out_valid_r |-> (out_level_r <= LVL_FOUR), "press level out of range")
  `ALD_ASSERT(a_ack_no_events, (p3_move && p3_ctrl_r.ack) |=> (out_new_r == '0), "acknowledge raised events")

endmodule

[tb/sv/averaged_level_detector_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// averaged_level_detector_tb
// Self-checking bench for the averaged level detector. A queue-fed driver
// offers sample and acknowledge requests, and an in-bench predictor of the
// window, the threshold levels and the event flags computes each expected
// report at its input transfer. A monitor checks every output transfer,
// field by field, in order. Thresholds and event enables change between
// phases while the block is idle. Both sides stall at random, and long
// output hold-offs make the block back up.
// ----------------------------------------------------------------------------
module averaged_level_detector_tb;
  import ald_pkg::*;

  localparam int unsigned WIN_DEPTH    = DEFAULT_WINDOW_DEPTH;
  localparam int unsigned SLOT_W       = $clog2(WIN_DEPTH);
  localparam int unsigned SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
  localparam int unsigned BYTE_MAX     = (1 << BYTE_W) - 1;
  localparam int unsigned EVENT_MAX    = (1 << EVENT_W) - 1;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned PHASE_ITEMS  = 150;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic                req_type;
    logic [SAMPLE_W-1:0] sample;
    logic [EVENT_W-1:0]  ack_mask;
  } request_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] avg_wide;
    logic [BYTE_W-1:0]   avg_byte;
    logic [LEVEL_W-1:0]  level;
    logic [EVENT_W-1:0]  raised;
    logic [EVENT_W-1:0]  pending;
    logic                irq;
  } report_t;

  logic                 clk;
  logic                 rst_n       = 1'b0;
  logic                 cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [CFG_W-1:0]     cfg_data    = '0;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  logic                 in_req_type = REQ_SAMPLE;
  logic [SAMPLE_W-1:0]  in_sample   = '0;
  logic [EVENT_W-1:0]   in_ack_mask = '0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  logic [SAMPLE_W-1:0]  out_average_wide;
  logic [BYTE_W-1:0]    out_average_byte;
  logic [LEVEL_W-1:0]   out_press_level;
  logic [EVENT_W-1:0]   out_new_events;
  logic [EVENT_W-1:0]   out_pending_events;
  logic                 out_irq;

  averaged_level_detector #(
    .WINDOW_DEPTH(WIN_DEPTH)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_sample          (in_sample),
    .in_ack_mask        (in_ack_mask),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_average_wide   (out_average_wide),
    .out_average_byte   (out_average_byte),
    .out_press_level    (out_press_level),
    .out_new_events     (out_new_events),
    .out_pending_events (out_pending_events),
    .out_irq            (out_irq)
  );

  // predictor state and its copy of the registers
  logic [SAMPLE_W-1:0] win_entry [WIN_DEPTH];
  logic [WIN_DEPTH-1:0] win_written = '0;
  logic [SAMPLE_W-1:0] win_fill = '0;
  int unsigned         win_sum = 0;
  logic [SLOT_W-1:0]   win_slot = '0;
  logic [LEVEL_W-1:0]  held_level = LVL_RELEASED;
  logic [EVENT_W-1:0]  pend_flags = '0;
  logic                primed = 1'b0;
  logic [BYTE_W-1:0]   lim_one = THRESH_ONE_RST;
  logic [BYTE_W-1:0]   lim_two = THRESH_TWO_RST;
  logic [BYTE_W-1:0]   lim_three = THRESH_THREE_RST;
  logic [BYTE_W-1:0]   lim_four = THRESH_FOUR_RST;
  logic [EVENT_W-1:0]  ev_enable = EVENT_ENABLE_RST;

  request_t pending_requests [$];
  report_t  expected_reports [$];
  request_t next_request;
  logic     in_taken = 1'b0;
  int       mismatches = 0;
  int       cycle_count = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       hold_requests = 0;
  int       holds_served = 0;
  int       hold_left = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // first threshold exceeded, in register order, decides the level
  function automatic logic [LEVEL_W-1:0] level_for(input logic [BYTE_W-1:0] b);
    if (b > lim_one) return LVL_RELEASED;
    if (b > lim_two) return LVL_ONE;
    if (b > lim_three) return LVL_TWO;
    if (b > lim_four) return LVL_THREE;
    return LVL_FOUR;
  endfunction

  // advance the detector by one request and return its report
  function automatic report_t advance_detector(input request_t rq);
    report_t             rp;
    logic [SAMPLE_W-1:0] oldest;
    logic [EVENT_W-1:0]  ev;
    int unsigned         wide;
    int unsigned         rounded;
    rp = '0;
    if (rq.req_type == REQ_ACK) begin
      pend_flags = pend_flags & ~rq.ack_mask;
      wide = (win_sum + WIN_DEPTH / 2) / WIN_DEPTH;
      rounded = (wide + 2) >> 2;
      rp.level = held_level;
    end else if (!primed) begin
      // first sample fills the whole window
      win_fill = rq.sample;
      win_written = '0;
      win_sum = rq.sample * WIN_DEPTH;
      win_slot = '0;
      wide = (win_sum + WIN_DEPTH / 2) / WIN_DEPTH;
      rounded = (wide + 2) >> 2;
      if (rounded > BYTE_MAX) rounded = BYTE_MAX;
      rp.level = level_for(rounded[BYTE_W-1:0]);
      held_level = rp.level;
      primed = 1'b1;
    end else begin
      // replace the oldest entry and update the running sum
      oldest = win_written[win_slot] ? win_entry[win_slot] : win_fill;
      win_sum = win_sum - oldest + rq.sample;
      win_entry[win_slot] = rq.sample;
      win_written[win_slot] = 1'b1;
      win_slot = (win_slot == WIN_DEPTH - 1) ? '0 : win_slot + 1'b1;
      wide = (win_sum + WIN_DEPTH / 2) / WIN_DEPTH;
      rounded = (wide + 2) >> 2;
      if (rounded > BYTE_MAX) rounded = BYTE_MAX;
      rp.level = level_for(rounded[BYTE_W-1:0]);
      if (ev_enable != '0) begin
        ev = '0;
        if (rp.level != LVL_RELEASED && rp.level > held_level) ev[rp.level - 1] = 1'b1;
        if (held_level != LVL_RELEASED && rp.level == LVL_RELEASED) ev[EV_RELEASE] = 1'b1;
        if (rp.level != held_level) ev[EV_CHANGE] = 1'b1;
        rp.raised = ev & ev_enable;
        pend_flags = pend_flags | rp.raised;
      end
      held_level = rp.level;
    end
    if (wide > SAMPLE_MAX) wide = SAMPLE_MAX;
    if (rounded > BYTE_MAX) rounded = BYTE_MAX;
    rp.avg_wide = wide[SAMPLE_W-1:0];
    rp.avg_byte = rounded[BYTE_W-1:0];
    rp.pending = pend_flags;
    rp.irq = (ev_enable != '0) && (pend_flags != '0);
    return rp;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      mismatches++;
    end
  endtask

  // input transfers feed the predictor, output transfers are checked in order
  always @(posedge clk) begin
    report_t exp_rp;
    cycle_count <= cycle_count + 1;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall)
      expected_reports.push_back(advance_detector({in_req_type, in_sample, in_ack_mask}));
    if (rst_n && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual wide %0d level %0d",
                 $time, out_average_wide, out_press_level);
        mismatches++;
      end else begin
        exp_rp = expected_reports.pop_front();
        check_field("average_wide", exp_rp.avg_wide, out_average_wide);
        check_field("average_byte", exp_rp.avg_byte, out_average_byte);
        check_field("press_level", exp_rp.level, out_press_level);
        check_field("new_events", exp_rp.raised, out_new_events);
        check_field("pending_events", exp_rp.pending, out_pending_events);
        check_field("irq", exp_rp.irq, out_irq);
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, expected_reports.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // driver: offer the next pending request once the current one is taken
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (rst_n && pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_request = pending_requests.pop_front();
        in_valid    <= 1'b1;
        in_req_type <= next_request.req_type;
        in_sample   <= next_request.sample;
        in_ack_mask <= next_request.ack_mask;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left    <= HOLD_CYCLES;
      out_stall    <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_THRESH_ONE:   lim_one = val[BYTE_W-1:0];
      CFG_THRESH_TWO:   lim_two = val[BYTE_W-1:0];
      CFG_THRESH_THREE: lim_three = val[BYTE_W-1:0];
      CFG_THRESH_FOUR:  lim_four = val[BYTE_W-1:0];
      CFG_EVENT_ENABLE: ev_enable = val[EVENT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_thresholds(input int unsigned t1, input int unsigned t2,
                                input int unsigned t3, input int unsigned t4);
    write_reg(CFG_THRESH_ONE, t1);
    write_reg(CFG_THRESH_TWO, t2);
    write_reg(CFG_THRESH_THREE, t3);
    write_reg(CFG_THRESH_FOUR, t4);
  endtask

  task automatic push_request(input logic req, input int unsigned smp, input int unsigned mask);
    request_t rq;
    rq.req_type = req;
    rq.sample   = smp[SAMPLE_W-1:0];
    rq.ack_mask = mask[EVENT_W-1:0];
    pending_requests.push_back(rq);
  endtask

  // sender pauses until every expected result is back, then the pipe empties
  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_valid || expected_reports.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // mostly plateaus around interesting levels, plus acknowledges and noise
  task automatic queue_random(input int count);
    int queued;
    int base;
    int spread;
    int run_len;
    int val;
    queued = 0;
    while (queued < count) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5, 6: begin
          case ($urandom_range(4))
            0:       base = 0;
            1:       base = SAMPLE_MAX;
            2:       base = $urandom_range(SAMPLE_MAX);
            3:       base = int'(lim_one) * 4 + 2;
            default: base = (($urandom_range(1) ? int'(lim_three) : int'(lim_four)) * 4);
          endcase
          spread = $urandom_range(1) ? $urandom_range(3) : $urandom_range(63);
          run_len = $urandom_range(20, 4);
          repeat (run_len) begin
            val = base + int'($urandom_range(2 * spread)) - spread;
            if (val < 0) val = 0;
            if (val > SAMPLE_MAX) val = SAMPLE_MAX;
            push_request(REQ_SAMPLE, val, $urandom_range(EVENT_MAX));
            queued++;
          end
        end
        7, 8: begin
          push_request(REQ_ACK, $urandom_range(SAMPLE_MAX), $urandom_range(EVENT_MAX));
          queued++;
        end
        default: begin
          push_request(REQ_SAMPLE, $urandom_range(SAMPLE_MAX), $urandom_range(EVENT_MAX));
          queued++;
        end
      endcase
    end
  endtask

  // stimulus and verdict
  initial begin
    int unsigned t1;
    int unsigned t2;
    int unsigned t3;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // defaults with every event enabled
    send_idle_pct = 16;
    recv_idle_pct = 85;
    set_thresholds(32'(THRESH_ONE_RST), 32'(THRESH_TWO_RST),
                   32'(THRESH_THREE_RST), 32'(THRESH_FOUR_RST));
    write_reg(CFG_EVENT_ENABLE, EVENT_MAX);

    // acknowledge before any sample, then a saturating prime, then a descent
    push_request(REQ_ACK, 0, EVENT_MAX);
    push_request(REQ_ACK, SAMPLE_MAX, 0);
    push_request(REQ_SAMPLE, SAMPLE_MAX, 0);
    repeat (WIN_DEPTH) push_request(REQ_SAMPLE, 0, EVENT_MAX);
    push_request(REQ_ACK, 0, 'h15);
    push_request(REQ_SAMPLE, 'h155, 'h2A);
    push_request(REQ_SAMPLE, 'h2AA, 'h15);
    push_request(REQ_ACK, 0, 'h2A);
    push_request(REQ_ACK, 0, EVENT_MAX);
    wait_drained();

    // unused register indexes must leave everything alone
    for (int k = CFG_EVENT_ENABLE + 1; k < (1 << CFG_IDX_W); k++)
      write_reg(CFG_IDX_W'(k), $urandom_range(BYTE_MAX));
    queue_random(PHASE_ITEMS);
    hold_requests++;
    wait_drained();

    // highest thresholds, some events enabled
    set_thresholds(BYTE_MAX, BYTE_MAX, BYTE_MAX, BYTE_MAX);
    write_reg(CFG_EVENT_ENABLE, $urandom_range(EVENT_MAX, 1));
    queue_random(PHASE_ITEMS);
    wait_drained();

    // sender now idles more than the receiver
    send_idle_pct = 85;
    recv_idle_pct = 16;
    set_thresholds(0, 0, 0, 0);
    write_reg(CFG_EVENT_ENABLE, EVENT_MAX);
    queue_random(PHASE_ITEMS);
    wait_drained();

    // arbitrary order of thresholds, events disabled but flags kept
    set_thresholds($urandom_range(BYTE_MAX), $urandom_range(BYTE_MAX),
                   $urandom_range(BYTE_MAX), $urandom_range(BYTE_MAX));
    write_reg(CFG_EVENT_ENABLE, 0);
    queue_random(PHASE_ITEMS);
    wait_drained();

    // no idling on either side, ascending thresholds
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_thresholds(10, 60, 120, 240);
    write_reg(CFG_EVENT_ENABLE, EVENT_MAX);
    queue_random(PHASE_ITEMS);
    hold_requests++;
    wait_drained();

    // random descending thresholds and random enables
    t1 = $urandom_range(BYTE_MAX);
    t2 = $urandom_range(t1);
    t3 = $urandom_range(t2);
    set_thresholds(t1, t2, t3, $urandom_range(t3));
    write_reg(CFG_EVENT_ENABLE, $urandom_range(EVENT_MAX));
    queue_random(PHASE_ITEMS);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
